### src/pmst_pkg.sv
`default_nettype none

package pmst_pkg;

    localparam int VTX_W = 5;
    localparam int WIN_W = 16;
    localparam int TOT_W = 21;
    localparam int CNT_W = 6;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_START = 1'b1;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = CNT_W'(32);

    typedef struct packed {
        logic clr_step;
        logic wr_en;
        logic run_init;
        logic scan_en;
        logic commit;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic pick_found;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### src/pmst_ctrl.sv
`default_nettype none

module pmst_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          req_type,
    output logic               in_stall,
    input  wire pmst_pkg::sts_t sts,
    output pmst_pkg::cmd_t     cmd
);
    import pmst_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROUND,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_START)
                    begin
                        cmd.run_init = 1'b1;
                        state_next   = ST_ROUND;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_ROUND:
            begin
                cmd.scan_en = 1'b1;
                if (sts.scan_done)
                begin
                    if (sts.pick_found)
                    begin
                        cmd.commit = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                cmd.emit_step = sts.out_free;
                if (sts.out_free && sts.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/pmst_dp.sv
`default_nettype none

module pmst_dp #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire pmst_pkg::cmd_t                 cmd,
    output pmst_pkg::sts_t                      sts,
    input  wire logic [pmst_pkg::CNT_W-1:0]     vertex_count,
    input  wire logic [pmst_pkg::VTX_W-1:0]     from_vertex,
    input  wire logic [pmst_pkg::VTX_W-1:0]     to_vertex,
    input  wire logic [pmst_pkg::WIN_W-1:0]     weight,
    input  wire logic                           out_stall,
    output logic                                out_valid,
    output logic [pmst_pkg::VTX_W-1:0]          vertex,
    output logic [pmst_pkg::VTX_W-1:0]          parent,
    output logic [pmst_pkg::WIN_W-1:0]          edge_weight,
    output logic                                reached,
    output logic [pmst_pkg::TOT_W-1:0]          total_weight,
    output logic                                last
);
    import pmst_pkg::*;

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int KW    = WEIGHT_BITS + 1;
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [KW-1:0] KEY_INF = KW'(1) << WEIGHT_BITS;

    // weight matrix, row = source vertex
    logic [WEIGHT_BITS-1:0] mem [DEPTH];
    logic [WEIGHT_BITS-1:0] rd_data_reg;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic                   wr_in_range;
    logic [AW-1:0]          clr_idx_reg;

    logic [NW-1:0]          n_act;
    logic [NW-1:0]          n_reg;
    logic [VW-1:0]          cur_reg;
    logic [NW-1:0]          scan_idx_reg;
    logic                   s1_valid_reg;
    logic [VW-1:0]          s1_idx_reg;

    logic [MAX_VERTICES-1:0] in_tree_reg;
    logic [MAX_VERTICES-1:0] key_vld_reg;
    logic [KW-1:0]           key_reg [MAX_VERTICES];
    logic [VW-1:0]           par_reg [MAX_VERTICES];

    logic                   pick_found_reg;
    logic [VW-1:0]          pick_idx_reg;
    logic [KW-1:0]          pick_key_reg;
    logic [TOT_W-1:0]       total_reg;
    logic [NW-1:0]          out_idx_reg;

    logic [KW-1:0]          key_cur;
    logic [KW-1:0]          cand;
    logic                   relax;
    logic                   issue;
    logic [VW-1:0]          emit_idx;
    logic                   emit_reached;
    logic                   emit_last;

    logic                   out_valid_reg;
    logic [VTX_W-1:0]       vertex_reg;
    logic [VTX_W-1:0]       parent_reg;
    logic [WIN_W-1:0]       edge_weight_reg;
    logic                   reached_reg;
    logic [TOT_W-1:0]       total_weight_reg;
    logic                   last_reg;

    always_comb
    begin
        if (vertex_count == '0)
        begin
            n_act = NW'(1);
        end
        else if (32'(vertex_count) > 32'(MAX_VERTICES))
        begin
            n_act = NW'(MAX_VERTICES);
        end
        else
        begin
            n_act = NW'(vertex_count);
        end
    end

    assign wr_in_range = (32'(from_vertex) < 32'(MAX_VERTICES))
                      && (32'(to_vertex) < 32'(MAX_VERTICES));
    assign wr_addr = AW'(VW'(from_vertex)) * AW'(MAX_VERTICES) + AW'(VW'(to_vertex));
    assign rd_addr = AW'(cur_reg) * AW'(MAX_VERTICES) + AW'(scan_idx_reg[VW-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (cmd.wr_en && wr_in_range)
        begin
            mem[wr_addr] <= WEIGHT_BITS'(weight);
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_idx_reg <= clr_idx_reg + AW'(1);
        end
    end

    // relaxation of the vertex read last cycle
    assign key_cur = key_vld_reg[s1_idx_reg] ? key_reg[s1_idx_reg] : KEY_INF;
    assign relax   = (rd_data_reg != '0) && ({1'b0, rd_data_reg} < key_cur);
    assign cand    = relax ? {1'b0, rd_data_reg} : key_cur;
    assign issue   = cmd.scan_en && (scan_idx_reg < n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            in_tree_reg    <= '0;
            key_vld_reg    <= '0;
            pick_found_reg <= 1'b0;
            out_idx_reg    <= '0;
        end
        else if (cmd.run_init)
        begin
            scan_idx_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            in_tree_reg    <= MAX_VERTICES'(1);
            key_vld_reg    <= '0;
            pick_found_reg <= 1'b0;
            out_idx_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= issue;
            if (cmd.commit)
            begin
                scan_idx_reg              <= '0;
                in_tree_reg[pick_idx_reg] <= 1'b1;
                pick_found_reg            <= 1'b0;
            end
            else if (issue)
            begin
                scan_idx_reg <= scan_idx_reg + NW'(1);
            end
            if (s1_valid_reg && !in_tree_reg[s1_idx_reg])
            begin
                if (relax)
                begin
                    key_vld_reg[s1_idx_reg] <= 1'b1;
                end
                if (cand < pick_key_reg)
                begin
                    pick_found_reg <= 1'b1;
                end
            end
            if (cmd.emit_step)
            begin
                out_idx_reg <= out_idx_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= scan_idx_reg[VW-1:0];
        if (cmd.run_init)
        begin
            n_reg        <= n_act;
            cur_reg      <= '0;
            pick_key_reg <= KEY_INF;
            total_reg    <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                cur_reg      <= pick_idx_reg;
                pick_key_reg <= KEY_INF;
                total_reg    <= total_reg + TOT_W'(pick_key_reg);
            end
            else if (s1_valid_reg && !in_tree_reg[s1_idx_reg] && (cand < pick_key_reg))
            begin
                pick_key_reg <= cand;
                pick_idx_reg <= s1_idx_reg;
            end
        end
        if (s1_valid_reg && !in_tree_reg[s1_idx_reg] && relax)
        begin
            key_reg[s1_idx_reg] <= cand;
            par_reg[s1_idx_reg] <= cur_reg;
        end
    end

    assign sts.clr_last   = (clr_idx_reg == AW'(DEPTH - 1));
    assign sts.scan_done  = (scan_idx_reg == n_reg) && !s1_valid_reg;
    assign sts.pick_found = pick_found_reg;
    assign sts.emit_last  = emit_last;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // result formatting
    assign emit_idx     = out_idx_reg[VW-1:0];
    assign emit_reached = in_tree_reg[emit_idx];
    assign emit_last    = (out_idx_reg == n_reg - NW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_step)
        begin
            vertex_reg  <= VTX_W'(emit_idx);
            reached_reg <= emit_reached;
            last_reg    <= emit_last;
            parent_reg  <= (emit_reached && key_vld_reg[emit_idx])
                         ? VTX_W'(par_reg[emit_idx]) : VTX_W'(emit_idx);
            edge_weight_reg <= (emit_reached && (emit_idx != '0))
                             ? WIN_W'(key_reg[emit_idx]) : '0;
            total_weight_reg <= emit_last ? total_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex       = vertex_reg;
    assign parent       = parent_reg;
    assign edge_weight  = edge_weight_reg;
    assign reached      = reached_reg;
    assign total_weight = total_weight_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

### src/prim_mst_dense_matrix.sv
// Edge write: one transfer per cycle while in_stall is low, no result.
// Start: r rounds, r = vertices reached, n = vertices in use; each round walks
//   one matrix row through the single read port. Then n results, one per cycle
//   while out_stall is low. One item is worked on at a time.
// Reset: the weight matrix is swept to zero entry by entry,
//   in_stall high meanwhile; vertex_count resets to 32.
`default_nettype none

module prim_mst_dense_matrix #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pmst_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [pmst_pkg::DATA_W-1:0]  pwdata,
    output logic [pmst_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         req_type,
    input  wire logic [pmst_pkg::VTX_W-1:0]   from_vertex,
    input  wire logic [pmst_pkg::VTX_W-1:0]   to_vertex,
    input  wire logic [pmst_pkg::WIN_W-1:0]   weight,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [pmst_pkg::VTX_W-1:0]        vertex,
    output logic [pmst_pkg::VTX_W-1:0]        parent,
    output logic [pmst_pkg::WIN_W-1:0]        edge_weight,
    output logic                              reached,
    output logic [pmst_pkg::TOT_W-1:0]        total_weight,
    output logic                              last
);
    import pmst_pkg::*;

    logic [CNT_W-1:0] vertex_count_reg;
    logic             reg_sel;
    cmd_t             cmd;
    sts_t             sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_VERTEX_COUNT);
    assign prdata  = reg_sel ? DATA_W'(vertex_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RST;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            vertex_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    pmst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pmst_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .vertex_count (vertex_count_reg),
        .from_vertex  (from_vertex),
        .to_vertex    (to_vertex),
        .weight       (weight),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .vertex       (vertex),
        .parent       (parent),
        .edge_weight  (edge_weight),
        .reached      (reached),
        .total_weight (total_weight),
        .last         (last)
    );

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pmst_pkg::*;

    typedef struct packed {
        logic [VTX_W-1:0] vtx;
        logic [VTX_W-1:0] par;
        logic [WIN_W-1:0] wgt;
        logic             hit;
        logic [TOT_W-1:0] total;
        logic             fin;
    } tree_row_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_EDGE, ROW_RUN} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [CNT_W-1:0] count;
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] dst;
        logic [WIN_W-1:0] wgt;
        logic             fixed;
        tree_row_t        known;
    } script_row_t;

    localparam int NUM_OPENING = 27;
    localparam int RANDOM_ITEMS = 420;
    localparam logic [ADDR_W-1:0] VCOUNT_ADDR = ADDR_W'(4 * REG_VERTEX_COUNT);

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_stall;
    logic                req_type;
    logic [VTX_W-1:0]    from_vertex;
    logic [VTX_W-1:0]    to_vertex;
    logic [WIN_W-1:0]    weight;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [VTX_W-1:0]    vertex;
    logic [VTX_W-1:0]    parent;
    logic [WIN_W-1:0]    edge_weight;
    logic                reached;
    logic [TOT_W-1:0]    total_weight;
    logic                last;

    logic [WIN_W-1:0]    weight_mat [32][32];
    logic [CNT_W-1:0]    vcount_model;
    tree_row_t           tree_rows_due [$];
    script_row_t         opening_rows [NUM_OPENING];

    bit                  calm = 1'b0;
    int                  stall_left = 0;
    int                  errors = 0;
    int                  edges_sent = 0;
    int                  runs_sent = 0;
    int                  rows_checked = 0;
    int                  settings_used = 0;

    prim_mst_dense_matrix u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .from_vertex  (from_vertex),
        .to_vertex    (to_vertex),
        .weight       (weight),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .vertex       (vertex),
        .parent       (parent),
        .edge_weight  (edge_weight),
        .reached      (reached),
        .total_weight (total_weight),
        .last         (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Prim from vertex 0 over the active vertices; one expected row per vertex
    function automatic void grow_tree();
        int          n;
        int          cur;
        int          pick;
        int unsigned pick_key;
        int unsigned e;
        int unsigned total;
        bit          joined [32];
        logic [4:0]  up [32];
        int unsigned key [32];
        tree_row_t   row;

        n = int'(vcount_model);
        if (n == 0)
            n = 1;
        if (n > 32)
            n = 32;
        for (int v = 0; v < 32; v++)
        begin
            joined[v] = 1'b0;
            up[v] = 5'(v);
            key[v] = 32'd65536;
        end
        cur = 0;
        total = 0;
        joined[0] = 1'b1;
        key[0] = 0;
        forever
        begin
            pick = n;
            pick_key = 32'd65536;
            for (int v = 0; v < n; v++)
            begin
                if (!joined[v])
                begin
                    e = weight_mat[cur][v];
                    if (e != 0 && e < key[v])
                    begin
                        key[v] = e;
                        up[v] = 5'(cur);
                    end
                    if (key[v] < pick_key)
                    begin
                        pick_key = key[v];
                        pick = v;
                    end
                end
            end
            if (pick >= n)
                break;
            joined[pick] = 1'b1;
            total += pick_key;
            cur = pick;
        end
        for (int v = 0; v < n; v++)
        begin
            row.vtx = 5'(v);
            row.par = joined[v] ? up[v] : 5'(v);
            row.wgt = (joined[v] && v != 0) ? 16'(key[v]) : '0;
            row.hit = joined[v];
            row.total = (v == n - 1) ? 21'(total) : '0;
            row.fin = (v == n - 1);
            tree_rows_due.push_back(row);
        end
    endfunction

    task automatic send_item(input logic rq, input logic [4:0] src, input logic [4:0] dst,
                             input logic [15:0] wgt, input logic fixed, input tree_row_t known);
        int gap;

        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        from_vertex <= src;
        to_vertex <= dst;
        weight <= wgt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (rq == REQ_WRITE)
        begin
            weight_mat[src][dst] = wgt;
            edges_sent++;
        end
        else
        begin
            grow_tree();
            if (fixed)
                tree_rows_due[tree_rows_due.size() - 1] = known;
            runs_sent++;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tree_rows_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_vertex_count(input logic [CNT_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= VCOUNT_ADDR;
        pwdata <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        vcount_model = value;
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        tree_row_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            if (tree_rows_due.size() == 0)
            begin
                $error("result transfer with nothing expected, vertex %0d", vertex);
                errors++;
            end
            else
            begin
                want = tree_rows_due.pop_front();
                rows_checked++;
                if (vertex !== want.vtx)
                begin
                    $error("vertex: expected %0d, got %0d", want.vtx, vertex);
                    errors++;
                end
                if (parent !== want.par)
                begin
                    $error("parent: expected %0d, got %0d", want.par, parent);
                    errors++;
                end
                if (edge_weight !== want.wgt)
                begin
                    $error("edge_weight: expected %0d, got %0d", want.wgt, edge_weight);
                    errors++;
                end
                if (reached !== want.hit)
                begin
                    $error("reached: expected %0d, got %0d", want.hit, reached);
                    errors++;
                end
                if (total_weight !== want.total)
                begin
                    $error("total_weight: expected %0d, got %0d", want.total, total_weight);
                    errors++;
                end
                if (last !== want.fin)
                begin
                    $error("last: expected %0d, got %0d", want.fin, last);
                    errors++;
                end
            end
            stall_left = calm ? 0 : $urandom_range(0, 3);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int          an;
        int          graphs;
        int          nw;
        int          phase;
        logic [5:0]  cnt;
        logic [4:0]  src;
        logic [4:0]  dst;
        logic [15:0] wgt;
        script_row_t r;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        req_type = REQ_WRITE;
        from_vertex = '0;
        to_vertex = '0;
        weight = '0;
        foreach (weight_mat[i, j])
            weight_mat[i][j] = '0;
        vcount_model = VERTEX_COUNT_RST;

        opening_rows = '{
            '{ROW_RUN,  6'd0,  5'd0,  5'd0,  16'h0000, 1'b1, '{5'd31, 5'd31, 16'h0, 1'b0, 21'd0, 1'b1}},
            '{ROW_CFG,  6'd1,  5'd0,  5'd0,  16'h0000, 1'b0, '0},
            '{ROW_RUN,  6'd0,  5'd0,  5'd0,  16'h0000, 1'b1, '{5'd0, 5'd0, 16'h0, 1'b1, 21'd0, 1'b1}},
            '{ROW_CFG,  6'd0,  5'd0,  5'd0,  16'h0000, 1'b0, '0},
            '{ROW_RUN,  6'd0,  5'd0,  5'd0,  16'h0000, 1'b1, '{5'd0, 5'd0, 16'h0, 1'b1, 21'd0, 1'b1}},
            '{ROW_CFG,  6'd63, 5'd0,  5'd0,  16'h0000, 1'b0, '0},
            '{ROW_EDGE, 6'd0,  5'd0,  5'd31, 16'hFFFF, 1'b0, '0},
            '{ROW_EDGE, 6'd0,  5'd31, 5'd31, 16'h0001, 1'b0, '0},
            '{ROW_EDGE, 6'd0,  5'd31, 5'd0,  16'h0001, 1'b0, '0},
            '{ROW_RUN,  6'd0,  5'd0,  5'd0,  16'h0000, 1'b1,
              '{5'd31, 5'd0, 16'hFFFF, 1'b1, 21'h0FFFF, 1'b1}},
            '{ROW_CFG,  6'd4,  5'd0,  5'd0,  16'h0000, 1'b0, '0},
            '{ROW_EDGE, 6'd0,  5'd0,  5'd1,  16'h0007, 1'b0, '0},
            '{ROW_EDGE, 6'd0,  5'd0,  5'd2,  16'h0003, 1'b0, '0},
            '{ROW_EDGE, 6'd0,  5'd1,  5'd3,  16'h0003, 1'b0, '0},
            '{ROW_EDGE, 6'd0,  5'd2,  5'd3,  16'h0003, 1'b0, '0},
            '{ROW_EDGE, 6'd0,  5'd0,  5'd10, 16'h0005, 1'b0, '0},
            '{ROW_EDGE, 6'd0,  5'd3,  5'd1,  16'h0002, 1'b0, '0},
            '{ROW_RUN,  6'd0,  5'd0,  5'd0,  16'h0000, 1'b0, '0},
            '{ROW_EDGE, 6'd0,  5'd2,  5'd1,  16'h0003, 1'b0, '0},
            '{ROW_RUN,  6'd0,  5'd0,  5'd0,  16'h0000, 1'b0, '0},
            '{ROW_CFG,  6'd32, 5'd0,  5'd0,  16'h0000, 1'b0, '0},
            '{ROW_EDGE, 6'd0,  5'd0,  5'd31, 16'h0000, 1'b0, '0},
            '{ROW_EDGE, 6'd0,  5'd5,  5'd0,  16'h0002, 1'b0, '0},
            '{ROW_RUN,  6'd0,  5'd0,  5'd0,  16'h0000, 1'b0, '0},
            '{ROW_EDGE, 6'd0,  5'd10, 5'd20, 16'h8001, 1'b0, '0},
            '{ROW_EDGE, 6'd0,  5'd20, 5'd21, 16'h7FFE, 1'b0, '0},
            '{ROW_RUN,  6'd0,  5'd0,  5'd0,  16'h0000, 1'b0, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_OPENING; i++)
        begin
            r = opening_rows[i];
            case (r.kind)
                ROW_CFG:
                begin
                    wait_drained();
                    set_vertex_count(r.count);
                end
                ROW_EDGE:
                    send_item(REQ_WRITE, r.src, r.dst, r.wgt, 1'b0, '0);
                default:
                    send_item(REQ_START, 5'd0, 5'd0, 16'h0, r.fixed, r.known);
            endcase
        end

        // random phases: count setting, then a few graphs each closed by a start
        phase = 0;
        while (edges_sent + runs_sent < 22 + RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       cnt = 6'($urandom_range(0, 1));
                1:       cnt = 6'd32;
                2:       cnt = 6'd63;
                3, 4:    cnt = 6'($urandom_range(9, 31));
                5:       cnt = 6'($urandom_range(0, 63));
                default: cnt = 6'($urandom_range(2, 8));
            endcase
            if (phase == 2)
                cnt = 6'd32;
            wait_drained();
            calm = ($urandom_range(0, 4) == 0);
            set_vertex_count(cnt);
            an = (cnt == 0) ? 1 : (cnt > 32) ? 32 : int'(cnt);

            if (phase == 2)
            begin
                // long chain of heaviest edges pushes the tree weight high
                for (int v = 0; v < 31; v++)
                    send_item(REQ_WRITE, 5'(v), 5'(v + 1), 16'hFFFF, 1'b0, '0);
                send_item(REQ_START, 5'd0, 5'd0, 16'h0, 1'b0, '0);
            end

            graphs = $urandom_range(1, 4);
            for (int g = 0; g < graphs; g++)
            begin
                nw = $urandom_range(0, (2 * an + 2 > 40) ? 40 : 2 * an + 2);
                for (int k = 0; k < nw; k++)
                begin
                    if ($urandom_range(0, 6) == 0)
                    begin
                        src = 5'($urandom_range(0, 31));
                        dst = 5'($urandom_range(0, 31));
                    end
                    else
                    begin
                        src = 5'($urandom_range(0, an - 1));
                        dst = 5'($urandom_range(0, an - 1));
                    end
                    case ($urandom_range(0, 9))
                        0:          wgt = 16'h0000;
                        1:          wgt = 16'hFFFF;
                        2, 3, 4:    wgt = 16'($urandom_range(1, 4));
                        default:    wgt = 16'($urandom_range(0, 65535));
                    endcase
                    send_item(REQ_WRITE, src, dst, wgt, 1'b0, '0);
                end
                if ((phase == 0 && g == 0) || $urandom_range(0, 5) == 0)
                    wait_drained();
                send_item(REQ_START, 5'($urandom), 5'($urandom), 16'($urandom), 1'b0, '0);
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (tree_rows_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("%0d edge writes and %0d tree runs sent over %0d count settings",
                 edges_sent, runs_sent, settings_used);
        $display("%0d result transfers checked field by field", rows_checked);
        if (errors == 0 && tree_rows_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
